[src/dwep_pkg.sv]
// ----------------------------------------------------------------------------
// dwep_pkg: shared types and constants for the EH pointer decoder
// Format codes, relative-mode codes, register indexes and the queue word.
// ----------------------------------------------------------------------------
package dwep_pkg;

  localparam logic [3:0] FMT_ABSPTR  = 4'h0;
  localparam logic [3:0] FMT_ULEB128 = 4'h1;
  localparam logic [3:0] FMT_UDATA2  = 4'h2;
  localparam logic [3:0] FMT_UDATA4  = 4'h3;
  localparam logic [3:0] FMT_UDATA8  = 4'h4;
  localparam logic [3:0] FMT_SLEB128 = 4'h9;
  localparam logic [3:0] FMT_SDATA2  = 4'ha;
  localparam logic [3:0] FMT_SDATA4  = 4'hb;
  localparam logic [3:0] FMT_SDATA8  = 4'hc;
  localparam logic [3:0] FMT_UDATA1  = 4'hd;
  localparam logic [3:0] FMT_SDATA1  = 4'he;

  localparam logic [7:0] OMIT_CODE = 8'hff;
  localparam logic [6:0] SHIFT_CAP = 7'd70;
  localparam logic [6:0] SHIFT_FULL = 7'd64;

  localparam logic [2:0] REL_NONE = 3'd0;
  localparam logic [2:0] REL_PC   = 3'd1;
  localparam logic [2:0] REL_TEXT = 3'd2;
  localparam logic [2:0] REL_DATA = 3'd3;
  localparam logic [2:0] REL_FUNC = 3'd4;

  localparam logic [1:0] CFG_PC   = 2'd0;
  localparam logic [1:0] CFG_TEXT = 2'd1;
  localparam logic [1:0] CFG_DATA = 2'd2;
  localparam logic [1:0] CFG_FUNC = 2'd3;

  localparam logic [63:0] PC_UNSET  = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] ADR_UNSET = 64'hffff_ffff_ffff_ffff;

  // decoded word waiting for its relative offset
  typedef struct packed {
    logic [63:0] value;
    logic        status;
    logic [2:0]  rel;
  } dwep_entry_t;

  // field length in bytes of a fixed format, 0 for LEB128 and unknown codes
  function automatic logic [3:0] fmt_fixed_len(input logic [3:0] fmt);
    logic [3:0] len;
    case (fmt)
      FMT_ABSPTR, FMT_UDATA8, FMT_SDATA8: len = 4'd8;
      FMT_UDATA4, FMT_SDATA4:             len = 4'd4;
      FMT_UDATA2, FMT_SDATA2:             len = 4'd2;
      FMT_UDATA1, FMT_SDATA1:             len = 4'd1;
      default:                            len = 4'd0;
    endcase
    return len;
  endfunction

  function automatic logic fmt_is_leb(input logic [3:0] fmt);
    return (fmt == FMT_ULEB128) || (fmt == FMT_SLEB128);
  endfunction

  function automatic logic fmt_is_signed(input logic [3:0] fmt);
    return (fmt == FMT_SDATA2) || (fmt == FMT_SDATA4) ||
           (fmt == FMT_SDATA8) || (fmt == FMT_SDATA1);
  endfunction

endpackage

[src/dwep_if.sv]
// ----------------------------------------------------------------------------
// dwep_if: stream channels of the EH pointer decoder
// Byte channel into the decoder and result channel out of it.
// ----------------------------------------------------------------------------
interface dwep_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [7:0] encoding;
  logic       start_value;

  modport source(output valid, output data_byte, output encoding, output start_value,
                 input ready);
  modport sink(input valid, input data_byte, input encoding, input start_value,
               output ready);
endinterface

interface dwep_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] decoded_value;
  logic        status;

  modport source(output valid, output decoded_value, output status, input ready);
  modport sink(input valid, input decoded_value, input status, output ready);
endinterface

[src/dwep_front.sv]
// ----------------------------------------------------------------------------
// dwep_front: byte accumulator of the EH pointer decoder
// One byte a cycle unless q_full; tracks the open run, pushes finished words.
// ----------------------------------------------------------------------------
module dwep_front
  import dwep_pkg::*;
#(
  parameter int ADDRESS_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst,
  dwep_in_if.sink     stream,
  input  logic        q_full,
  output logic        q_push,
  output dwep_entry_t q_word
);

  logic [63:0] accumulator, accumulator_next;
  logic [6:0]  bit_shift, bit_shift_next;
  logic [3:0]  bytes_left, bytes_left_next;
  logic [7:0]  active_encoding, active_encoding_next;
  logic        busy, busy_next;

  logic        fire;
  logic [3:0]  start_len;
  logic        start_known;
  logic [63:0] cur_acc;
  logic [6:0]  cur_shift;
  logic [3:0]  cur_left;
  logic [7:0]  cur_enc;
  logic [3:0]  fmt;
  logic        leb;
  logic [63:0] payload;
  logic [63:0] acc_or;
  logic [7:0]  shift_sum;
  logic [6:0]  new_shift;
  logic [3:0]  new_left;
  logic        done;
  logic        ext;
  logic [5:0]  sign_idx;
  logic [63:0] ext_mask;
  logic [63:0] acc_final;

  assign stream.ready = !q_full;
  assign fire = stream.valid && stream.ready;

  always_comb begin
    start_len   = fmt_fixed_len(stream.encoding[3:0]);
    start_known = fmt_is_leb(stream.encoding[3:0]) || (start_len != 4'd0);
    if ((stream.encoding[3:0] == FMT_ABSPTR) && (ADDRESS_BYTES != 8)) begin
      start_known = 1'b0;
    end
  end

  // a start item opens a fresh run
  assign cur_acc   = stream.start_value ? 64'd0 : accumulator;
  assign cur_shift = stream.start_value ? 7'd0 : bit_shift;
  assign cur_left  = stream.start_value ? start_len : bytes_left;
  assign cur_enc   = stream.start_value ? stream.encoding : active_encoding;
  assign fmt       = cur_enc[3:0];
  assign leb       = fmt_is_leb(fmt);

  always_comb begin
    payload = leb ? {57'd0, stream.data_byte[6:0]} : {56'd0, stream.data_byte};
    acc_or  = cur_acc;
    if (!cur_shift[6]) begin
      acc_or = cur_acc | (payload << cur_shift[5:0]);
    end

    shift_sum = {1'b0, cur_shift} + (leb ? 8'd7 : 8'd8);
    if (leb) begin
      new_shift = (shift_sum > {1'b0, SHIFT_CAP}) ? SHIFT_CAP : shift_sum[6:0];
    end else begin
      new_shift = (shift_sum > {1'b0, SHIFT_FULL}) ? SHIFT_FULL : shift_sum[6:0];
    end

    new_left = (cur_left != 4'd0) ? cur_left - 4'd1 : 4'd0;
    done     = leb ? !stream.data_byte[7] : (new_left == 4'd0);

    sign_idx = new_shift[5:0] - 6'd1;
    if (leb) begin
      ext = (fmt == FMT_SLEB128) && stream.data_byte[6] && !new_shift[6];
    end else begin
      ext = fmt_is_signed(fmt) && (new_shift != 7'd0) && !new_shift[6] &&
            acc_or[sign_idx];
    end
    ext_mask  = {64{1'b1}} << new_shift[5:0];
    acc_final = ext ? (acc_or | ext_mask) : acc_or;
  end

  always_comb begin
    accumulator_next     = accumulator;
    bit_shift_next       = bit_shift;
    bytes_left_next      = bytes_left;
    active_encoding_next = active_encoding;
    busy_next            = busy;
    q_push               = 1'b0;
    q_word               = '{value: acc_final, status: 1'b0, rel: cur_enc[6:4]};

    if (fire && (stream.start_value || busy)) begin
      if (stream.start_value) begin
        active_encoding_next = stream.encoding;
      end
      if (stream.start_value && (stream.encoding == OMIT_CODE)) begin
        q_push    = 1'b1;
        q_word    = '{value: 64'd0, status: 1'b0, rel: REL_NONE};
        busy_next = 1'b0;
        accumulator_next = 64'd0;
        bit_shift_next   = 7'd0;
        bytes_left_next  = 4'd0;
      end else if (stream.start_value && !start_known) begin
        q_push    = 1'b1;
        q_word    = '{value: 64'd0, status: 1'b1, rel: REL_NONE};
        busy_next = 1'b0;
        accumulator_next = 64'd0;
        bit_shift_next   = 7'd0;
        bytes_left_next  = 4'd0;
      end else begin
        accumulator_next = acc_or;
        bit_shift_next   = new_shift;
        bytes_left_next  = leb ? cur_left : new_left;
        busy_next        = !done;
        q_push           = done;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator     <= 64'd0;
      bit_shift       <= 7'd0;
      bytes_left      <= 4'd0;
      active_encoding <= 8'd0;
      busy            <= 1'b0;
    end else begin
      accumulator     <= accumulator_next;
      bit_shift       <= bit_shift_next;
      bytes_left      <= bytes_left_next;
      active_encoding <= active_encoding_next;
      busy            <= busy_next;
    end
  end

endmodule

[src/dwep_queue.sv]
// ----------------------------------------------------------------------------
// dwep_queue: two-entry queue between decoder front and back
// Holds finished words so each side can stall on its own.
// ----------------------------------------------------------------------------
module dwep_queue
  import dwep_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  dwep_entry_t push_word,
  input  logic        pop,
  output dwep_entry_t pop_word,
  output logic        full,
  output logic        empty
);

  dwep_entry_t slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_word = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[src/dwep_back.sv]
// ----------------------------------------------------------------------------
// dwep_back: offset adder and output register of the EH pointer decoder
// Adds the selected relative offset and holds the result word.
// ----------------------------------------------------------------------------
module dwep_back
  import dwep_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        q_empty,
  input  dwep_entry_t q_word,
  output logic        q_pop,
  dwep_out_if.source  result
);

  logic [63:0] pc_offset;
  logic [63:0] text_offset;
  logic [63:0] data_offset;
  logic [63:0] func_offset;

  logic        out_valid;
  logic [63:0] out_value;
  logic        out_status;
  logic [63:0] addend;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc_offset   <= PC_UNSET;
      text_offset <= ADR_UNSET;
      data_offset <= ADR_UNSET;
      func_offset <= ADR_UNSET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PC:   pc_offset   <= cfg_data;
        CFG_TEXT: text_offset <= cfg_data;
        CFG_DATA: data_offset <= cfg_data;
        CFG_FUNC: func_offset <= cfg_data;
        default:  pc_offset   <= pc_offset;
      endcase
    end
  end

  // unset offsets add nothing
  always_comb begin
    case (q_word.rel)
      REL_PC:   addend = (pc_offset   != PC_UNSET)  ? pc_offset   : 64'd0;
      REL_TEXT: addend = (text_offset != ADR_UNSET) ? text_offset : 64'd0;
      REL_DATA: addend = (data_offset != ADR_UNSET) ? data_offset : 64'd0;
      REL_FUNC: addend = (func_offset != ADR_UNSET) ? func_offset : 64'd0;
      default:  addend = 64'd0;
    endcase
  end

  assign q_pop = !q_empty && (!out_valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_value  <= q_word.value + addend;
      out_status <= q_word.status;
    end
  end

  assign result.valid         = out_valid;
  assign result.decoded_value = out_value;
  assign result.status        = out_status;

endmodule

[src/dwarf_eh_pointer_decoder_core.sv]
// Path: the byte that completes a word is accumulated by the front and written
//   into the queue when it is accepted; the offset add then writes it into the
//   output register, once the output register is free.
// Throughput: one byte per cycle; the front takes a byte whenever the
//   two-entry queue has room, independent of output stalls.
// Reset (rst, synchronous): clears the open run, queue and output valid;
//   the offset registers return to their unset values.
// ----------------------------------------------------------------------------
// dwarf_eh_pointer_decoder_core: DWARF EH pointer encoding decoder
// Decodes fixed, absolute and LEB128 encoded values and adds the
// relative offset chosen by the encoding.
// ----------------------------------------------------------------------------
module dwarf_eh_pointer_decoder_core
  import dwep_pkg::*;
#(
  parameter int ADDRESS_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst,
  dwep_in_if.sink     stream,
  dwep_out_if.source  result,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_empty;
  dwep_entry_t push_word;
  dwep_entry_t pop_word;

  dwep_front #(
    .ADDRESS_BYTES(ADDRESS_BYTES)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .stream (stream),
    .q_full (q_full),
    .q_push (q_push),
    .q_word (push_word)
  );

  dwep_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_word (push_word),
    .pop       (q_pop),
    .pop_word  (pop_word),
    .full      (q_full),
    .empty     (q_empty)
  );

  dwep_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_empty   (q_empty),
    .q_word    (pop_word),
    .q_pop     (q_pop),
    .result    (result)
  );

endmodule
